// ----- sv/sbsp_pkg.sv -----
// ----------------------------------------------------------------------------
// Seekable byte stream ports package
// Shared constants, codes and handshake structures for the port block.
// ----------------------------------------------------------------------------
package sbsp_pkg;

  // Store geometry.
  localparam int unsigned INPUT_DEPTH = 32768;
  localparam int unsigned FILE_DEPTH  = 262144;
  localparam int unsigned IN_AW       = $clog2(INPUT_DEPTH);
  localparam int unsigned FILE_AW     = $clog2(FILE_DEPTH);

  // Field widths fixed by the port definition.
  localparam int unsigned IN_PTR_W   = 16;
  localparam int unsigned FILE_PTR_W = 24;
  localparam int unsigned IN_SIZE_W  = 16;
  localparam int unsigned FILE_SIZE_W = 19;
  localparam int unsigned CFG_DATA_W = 19;
  localparam int unsigned LOAD_W     = 18;

  // Access kinds carried in the mode field.
  typedef enum logic [1:0] {
    MODE_READ      = 2'd0,
    MODE_WRITE     = 2'd1,
    MODE_LOAD_IN   = 2'd2,
    MODE_LOAD_FILE = 2'd3
  } mode_t;

  // Port numbers with a meaning.
  localparam logic [7:0] PORT_CONSOLE   = 8'd0;
  localparam logic [7:0] PORT_IN_SEEK   = 8'd1;
  localparam logic [7:0] PORT_FILE      = 8'd2;
  localparam logic [7:0] PORT_FILE_SEEK = 8'd3;
  localparam logic [7:0] PORT_ERROR     = 8'd4;

  // Configuration register indexes.
  localparam logic CFG_INPUT_SIZE = 1'b0;
  localparam logic CFG_FILE_SIZE  = 1'b1;

  // Request toward the input store.
  typedef struct packed {
    logic             we;
    logic [IN_AW-1:0] waddr;
    logic [7:0]       wdata;
    logic             re;
    logic [IN_AW-1:0] raddr;
  } in_req_t;

  // Request toward the file store.
  typedef struct packed {
    logic               we;
    logic [FILE_AW-1:0] waddr;
    logic [7:0]         wdata;
    logic               re;
    logic [FILE_AW-1:0] raddr;
  } file_req_t;

  // Result fields decided at accept time, plus which store read to pick up.
  typedef struct packed {
    logic       rd_in;
    logic       rd_file;
    logic [7:0] rd_val;
    logic       emit;
    logic       chan;
    logic [7:0] emit_val;
    logic       bad;
  } meta_t;

endpackage

// ----- sv/seekable_byte_stream_ports_core.sv -----
// ----------------------------------------------------------------------------
// Seekable byte stream ports core
// Port block behind an emulated CPU with an input stream and a file device.
// ----------------------------------------------------------------------------
// Usage: each input transaction (in_valid, in_stall) carries one access:
// a port read, a port write, or a preload byte for the input or file store.
// Every accepted transaction yields exactly one result transaction on the
// out_ channel (out_valid, out_stall), in order.
// From acceptance to the result a transaction passes the read stage and the
// output register: the store RAM is read at the accepting edge and the output
// register loads when the read stage advances; from then on out_valid is high.
// Throughput is one transaction per cycle while the receiver does not stall;
// pointers are updated at accept time and each transaction touches one entry of one store.
// When the receiver stalls, the output holds and one more transaction
// waits in the read stage; after that in_stall rises until out_stall falls.
// The cfg_ port is always ready and sets the two valid sizes.
// Reset clears the pointers, seek state and sizes; the stores are not
// cleared and must be preloaded before their entries are read.
// ----------------------------------------------------------------------------
module seekable_byte_stream_ports_core
  import sbsp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_mode,
  input  logic [7:0]            in_port,
  input  logic [7:0]            in_data,
  input  logic [LOAD_W-1:0]     in_load_addr,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_read_data,
  output logic                  out_out_valid,
  output logic                  out_out_channel,
  output logic [7:0]            out_out_byte,
  output logic                  out_bad_port
);

  in_req_t   in_req;
  file_req_t file_req;
  meta_t     meta;
  logic [7:0] in_rdata;
  logic [7:0] file_rdata;
  logic      accept;
  logic      a_adv;
  logic      a_valid_r;
  meta_t     a_meta_r;
  logic      out_valid_r;
  logic [7:0] rd_sel;

  // Handshake: the read stage moves on when the output register is empty or its result is taken.
  assign cfg_ready = 1'b1;
  assign a_adv     = !out_valid_r || !out_stall;
  assign in_stall  = a_valid_r && !a_adv;
  assign accept    = in_valid && !in_stall;

  sbsp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .mode      (in_mode),
    .port      (in_port),
    .data      (in_data),
    .load_addr (in_load_addr),
    .in_req    (in_req),
    .file_req  (file_req),
    .meta      (meta)
  );

  sbsp_ram #(.WIDTH(8), .DEPTH(INPUT_DEPTH)) u_in_ram (
    .clk   (clk),
    .we    (in_req.we),
    .waddr (in_req.waddr),
    .wdata (in_req.wdata),
    .re    (in_req.re),
    .raddr (in_req.raddr),
    .rdata (in_rdata)
  );

  sbsp_ram #(.WIDTH(8), .DEPTH(FILE_DEPTH)) u_file_ram (
    .clk   (clk),
    .we    (file_req.we),
    .waddr (file_req.waddr),
    .wdata (file_req.wdata),
    .re    (file_req.re),
    .raddr (file_req.raddr),
    .rdata (file_rdata)
  );

  // Pick the returned byte from the store that was read, if any.
  always_comb begin
    if (a_meta_r.rd_in) begin
      rd_sel = in_rdata;
    end else if (a_meta_r.rd_file) begin
      rd_sel = file_rdata;
    end else begin
      rd_sel = a_meta_r.rd_val;
    end
  end

  // Stage valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        a_valid_r <= 1'b1;
      end else if (a_adv) begin
        a_valid_r <= 1'b0;
      end
      if (a_valid_r && a_adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (accept) begin
      a_meta_r <= meta;
    end
    if (a_valid_r && a_adv) begin
      out_read_data   <= rd_sel;
      out_out_valid   <= a_meta_r.emit;
      out_out_channel <= a_meta_r.chan;
      out_out_byte    <= a_meta_r.emit_val;
      out_bad_port    <= a_meta_r.bad;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- sv/sbsp_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module sbsp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write and registered read; the read data holds while re is low.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/sbsp_ctrl.sv -----
// ----------------------------------------------------------------------------
// Port decoder and pointer control
// Holds the size registers and both stream pointers, decodes each accepted
// transaction and issues the store reads and writes that it needs.
// ----------------------------------------------------------------------------
module sbsp_ctrl
  import sbsp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  accept,
  input  logic [1:0]            mode,
  input  logic [7:0]            port,
  input  logic [7:0]            data,
  input  logic [LOAD_W-1:0]     load_addr,
  output in_req_t               in_req,
  output file_req_t             file_req,
  output meta_t                 meta
);

  localparam logic [IN_PTR_W:0]   IN_DEPTH_V   = (IN_PTR_W+1)'(INPUT_DEPTH);
  localparam logic [FILE_PTR_W:0] FILE_DEPTH_V = (FILE_PTR_W+1)'(FILE_DEPTH);

  logic [IN_SIZE_W-1:0]   input_size_r;
  logic [FILE_SIZE_W-1:0] file_size_r;
  logic [IN_PTR_W-1:0]    in_ptr_r, in_ptr_nxt;
  logic                   phase_r, phase_nxt;
  logic [FILE_PTR_W-1:0]  file_ptr_r, file_ptr_nxt;
  logic [1:0]             seek_cnt_r, seek_cnt_nxt;

  logic [IN_PTR_W:0]     in_cap;
  logic [FILE_PTR_W:0]   file_cap;
  logic [FILE_PTR_W:0]   load_ext;
  logic                  in_avail;
  logic                  file_avail;

  // Valid sizes capped at the store depths, and end-of-data checks.
  always_comb begin
    in_cap = ({1'b0, input_size_r} < IN_DEPTH_V) ? {1'b0, input_size_r} : IN_DEPTH_V;
    file_cap = ((FILE_PTR_W+1)'(file_size_r) < FILE_DEPTH_V) ?
               (FILE_PTR_W+1)'(file_size_r) : FILE_DEPTH_V;
    load_ext   = (FILE_PTR_W+1)'(load_addr);
    in_avail   = {1'b0, in_ptr_r} < in_cap;
    file_avail = {1'b0, file_ptr_r} < file_cap;
  end

  // Decode of one transaction.
  always_comb begin
    in_ptr_nxt   = in_ptr_r;
    phase_nxt    = phase_r;
    file_ptr_nxt = file_ptr_r;
    seek_cnt_nxt = seek_cnt_r;
    meta         = '0;
    in_req       = '0;
    file_req     = '0;
    in_req.raddr  = in_ptr_r[IN_AW-1:0];
    file_req.raddr = file_ptr_r[FILE_AW-1:0];
    in_req.wdata  = data;
    file_req.wdata = data;
    in_req.waddr  = load_ext[IN_AW-1:0];
    file_req.waddr = load_ext[FILE_AW-1:0];
    if (accept) begin
      case (mode_t'(mode))
        MODE_LOAD_IN: begin
          in_req.we = load_ext < (FILE_PTR_W+1)'(INPUT_DEPTH);
        end
        MODE_LOAD_FILE: begin
          file_req.we = load_ext < FILE_DEPTH_V;
        end
        MODE_READ: begin
          case (port)
            PORT_CONSOLE: begin
              if (in_avail) begin
                in_req.re   = 1'b1;
                meta.rd_in  = 1'b1;
                in_ptr_nxt  = in_ptr_r + IN_PTR_W'(1);
              end
            end
            PORT_IN_SEEK: begin
              meta.rd_val = phase_r ? in_ptr_r[7:0] : in_ptr_r[15:8];
              phase_nxt   = ~phase_r;
            end
            PORT_FILE: begin
              if (file_avail) begin
                file_req.re  = 1'b1;
                meta.rd_file = 1'b1;
                file_ptr_nxt = file_ptr_r + FILE_PTR_W'(1);
              end
            end
            PORT_FILE_SEEK: begin
              meta.rd_val = (seek_cnt_r != 2'd0) ? {6'd0, seek_cnt_r}
                                                 : {7'd0, ~file_avail};
            end
            default: begin
              meta.bad = 1'b1;
            end
          endcase
        end
        MODE_WRITE: begin
          case (port)
            PORT_CONSOLE, PORT_ERROR: begin
              meta.emit     = 1'b1;
              meta.chan     = (port == PORT_ERROR);
              meta.emit_val = data;
            end
            PORT_IN_SEEK: begin
              in_ptr_nxt = phase_r ? (in_ptr_r | {8'd0, data}) : {data, 8'd0};
              phase_nxt  = ~phase_r;
            end
            PORT_FILE: begin
              if (file_avail) begin
                file_req.we    = 1'b1;
                file_req.waddr = file_ptr_r[FILE_AW-1:0];
                file_ptr_nxt   = file_ptr_r + FILE_PTR_W'(1);
              end
            end
            PORT_FILE_SEEK: begin
              case (seek_cnt_r)
                2'd0: begin
                  file_ptr_nxt = {data, 16'd0};
                  seek_cnt_nxt = 2'd1;
                end
                2'd1: begin
                  file_ptr_nxt = file_ptr_r | {8'd0, data, 8'd0};
                  seek_cnt_nxt = 2'd2;
                end
                default: begin
                  file_ptr_nxt = file_ptr_r | {16'd0, data};
                  seek_cnt_nxt = 2'd0;
                end
              endcase
            end
            default: begin
              meta.bad = 1'b1;
            end
          endcase
        end
        default: begin
          meta.bad = 1'b0;
        end
      endcase
    end
  end

  // Pointer state and size registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      input_size_r <= '0;
      file_size_r  <= '0;
      in_ptr_r     <= '0;
      phase_r      <= 1'b0;
      file_ptr_r   <= '0;
      seek_cnt_r   <= 2'd0;
    end else begin
      in_ptr_r   <= in_ptr_nxt;
      phase_r    <= phase_nxt;
      file_ptr_r <= file_ptr_nxt;
      seek_cnt_r <= seek_cnt_nxt;
      if (cfg_valid && (cfg_index == CFG_INPUT_SIZE)) begin
        input_size_r <= cfg_data[IN_SIZE_W-1:0];
      end
      if (cfg_valid && (cfg_index == CFG_FILE_SIZE)) begin
        file_size_r <= cfg_data[FILE_SIZE_W-1:0];
      end
    end
  end

endmodule

// ----- sv/sbsp_checker.sv -----
// ----------------------------------------------------------------------------
// Seekable byte stream ports checker
// Port-level assertions for the core, attached by a bind statement.
// ----------------------------------------------------------------------------
module sbsp_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [7:0]            out_read_data,
  input logic                  out_out_valid,
  input logic                  out_out_channel,
  input logic [7:0]            out_out_byte,
  input logic                  out_bad_port
);

  // No result is presented in the cycle after reset.
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // The input side only stalls when a result is held by a stalled receiver.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without output back-pressure");

  // A transaction that emits no console byte reports channel and byte as zero.
  a_emit_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_out_valid) |-> (!out_out_channel && (out_out_byte == 8'd0)))
    else $error("console fields set without emission");

  // An unknown port returns no data and emits nothing.
  a_bad_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_bad_port) |-> ((out_read_data == 8'd0) && !out_out_valid))
    else $error("unknown port produced data");

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_read_data)
                                  && $stable(out_bad_port)))
    else $error("stalled result changed");

endmodule

bind seekable_byte_stream_ports_core sbsp_checker u_sbsp_checker (.*);
